// ----- rtl/block_average_pixelate_core_macros.svh -----
// assertion macros for the block average pixelate core
`ifndef BLOCK_AVERAGE_PIXELATE_CORE_MACROS_SVH
`define BLOCK_AVERAGE_PIXELATE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bap_pkg.sv -----
// shared types, constants and tables of the block average pixelate core
package bap_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_BLOCK  = 16;
    localparam int BS_W       = $clog2(MAX_BLOCK);
    localparam int SUM_W      = 16;
    localparam int RECIP_SH   = 24;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [4:0]  RST_BLOCK_SIZE   = 5'd10;
    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

    // ceil(2^24 / (k*k)) for block sizes 1..16, exact floor for sums below 2^16
    localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_BLOCK] = '{
        RECIP_W'(((1 << RECIP_SH) +   1 - 1) /   1),
        RECIP_W'(((1 << RECIP_SH) +   4 - 1) /   4),
        RECIP_W'(((1 << RECIP_SH) +   9 - 1) /   9),
        RECIP_W'(((1 << RECIP_SH) +  16 - 1) /  16),
        RECIP_W'(((1 << RECIP_SH) +  25 - 1) /  25),
        RECIP_W'(((1 << RECIP_SH) +  36 - 1) /  36),
        RECIP_W'(((1 << RECIP_SH) +  49 - 1) /  49),
        RECIP_W'(((1 << RECIP_SH) +  64 - 1) /  64),
        RECIP_W'(((1 << RECIP_SH) +  81 - 1) /  81),
        RECIP_W'(((1 << RECIP_SH) + 100 - 1) / 100),
        RECIP_W'(((1 << RECIP_SH) + 121 - 1) / 121),
        RECIP_W'(((1 << RECIP_SH) + 144 - 1) / 144),
        RECIP_W'(((1 << RECIP_SH) + 169 - 1) / 169),
        RECIP_W'(((1 << RECIP_SH) + 196 - 1) / 196),
        RECIP_W'(((1 << RECIP_SH) + 225 - 1) / 225),
        RECIP_W'(((1 << RECIP_SH) + 256 - 1) / 256)
    };

    typedef struct packed {
        logic [BS_W-1:0]    bs_m1;
        logic [COL_W-1:0]   w_m1;
        logic [COL_W-1:0]   h_m1;
        logic [RECIP_W-1:0] recip;
        logic               restart;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_sums;

    typedef struct packed {
        logic [COL_W-1:0] block_col;
        logic [COL_W-1:0] block_row;
        logic             done;
    } t_meta;

    typedef struct packed {
        t_meta      meta;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    function automatic logic [BS_W-1:0] clamp_bs_m1(input logic [4:0] v);
        logic [BS_W-1:0] res;
        if (v == 5'd0) begin
            res = '0;
        end else if (v > 5'(MAX_BLOCK)) begin
            res = BS_W'(MAX_BLOCK - 1);
        end else begin
            res = BS_W'(v - 5'd1);
        end
        return res;
    endfunction

    function automatic logic [COL_W-1:0] clamp_dim_m1(input logic [12:0] v);
        logic [COL_W-1:0] res;
        if (v == 13'd0) begin
            res = '0;
        end else if (v > 13'(MAX_WIDTH)) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - 13'd1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/bap_cfg_regs.sv -----
// configuration registers with apb-style access and derived geometry
module bap_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bap_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output bap_pkg::t_cfg              o_cfg
);

    logic [4:0]  r_block_size;
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic        w_wr;
    logic        w_hit;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    always_comb begin
        case (w_idx)
            bap_pkg::REG_BLOCK_SIZE,
            bap_pkg::REG_IMAGE_WIDTH,
            bap_pkg::REG_IMAGE_HEIGHT: w_hit = w_wr;
            default:                   w_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= bap_pkg::RST_BLOCK_SIZE;
            r_image_width  <= bap_pkg::RST_IMAGE_WIDTH;
            r_image_height <= bap_pkg::RST_IMAGE_HEIGHT;
        end else if (w_wr) begin
            case (w_idx)
                bap_pkg::REG_BLOCK_SIZE:   r_block_size   <= pwdata[4:0];
                bap_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[12:0];
                bap_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bap_pkg::REG_BLOCK_SIZE:   prdata = 32'(r_block_size);
            bap_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            bap_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.bs_m1   = bap_pkg::clamp_bs_m1(r_block_size);
        o_cfg.w_m1    = bap_pkg::clamp_dim_m1(r_image_width);
        o_cfg.h_m1    = bap_pkg::clamp_dim_m1(r_image_height);
        o_cfg.recip   = bap_pkg::RECIP_TAB[o_cfg.bs_m1];
        o_cfg.restart = w_hit;
    end

endmodule

// ----- rtl/bap_sum_ram.sv -----
// per block column sum memory, one write and one registered read port
module bap_sum_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bap_pkg::COL_W-1:0] i_waddr,
    input  bap_pkg::t_sums            i_wdata,
    input  logic                      i_re,
    input  logic [bap_pkg::COL_W-1:0] i_raddr,
    output bap_pkg::t_sums            o_rdata
);

    bap_pkg::t_sums mem [bap_pkg::MAX_WIDTH];
    bap_pkg::t_sums r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bap_recip_div.sv -----
// divides three block sums by the block area through a reciprocal multiply
module bap_recip_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  bap_pkg::t_sums              i_sums,
    input  bap_pkg::t_meta              i_meta,
    input  logic [bap_pkg::RECIP_W-1:0] i_recip,
    output logic                        o_valid,
    output bap_pkg::t_result            o_result
);

    logic [bap_pkg::PROD_W-1:0] r_prod_r;
    logic [bap_pkg::PROD_W-1:0] r_prod_g;
    logic [bap_pkg::PROD_W-1:0] r_prod_b;
    bap_pkg::t_meta             r_meta;
    logic                       r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_prod_r <= bap_pkg::PROD_W'(i_sums.r) * bap_pkg::PROD_W'(i_recip);
            r_prod_g <= bap_pkg::PROD_W'(i_sums.g) * bap_pkg::PROD_W'(i_recip);
            r_prod_b <= bap_pkg::PROD_W'(i_sums.b) * bap_pkg::PROD_W'(i_recip);
            r_meta   <= i_meta;
        end
    end

    // quotient never exceeds 255, so the bits above are zero
    assign o_valid        = r_valid;
    assign o_result.meta  = r_meta;
    assign o_result.red   = r_prod_r[bap_pkg::RECIP_SH+7:bap_pkg::RECIP_SH];
    assign o_result.green = r_prod_g[bap_pkg::RECIP_SH+7:bap_pkg::RECIP_SH];
    assign o_result.blue  = r_prod_b[bap_pkg::RECIP_SH+7:bap_pkg::RECIP_SH];

endmodule

// ----- rtl/bap_out_fifo.sv -----
// result queue between the datapath and the output channel
module bap_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bap_pkg::t_result            i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output bap_pkg::t_result            o_data,
    output logic [bap_pkg::FIFO_CW-1:0] o_count
);

    bap_pkg::t_result             r_buf [bap_pkg::FIFO_DEPTH];
    logic [bap_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [bap_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [bap_pkg::FIFO_CW-1:0]  r_count;
    logic                         w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = i_pop & o_valid;
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/block_average_pixelate_core.sv -----
// block average pixelate core: raster pixels in, one average word per finished block out
// a result word passes stage 1, stage 2, the divider register and the result queue before it shows on o_valid
// throughput: one pixel per cycle while o_stall is low, using the one read and one write port of the sum memory
// o_stall rises when the 8-word result queue plus in-flight results would fill
// reset and every valid register write start a clear of every sum memory address,
// with o_stall high, and send the pixel position back to the image origin
`include "block_average_pixelate_core_macros.svh"

module block_average_pixelate_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bap_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_red_in,
    input  logic [7:0]                          i_green_in,
    input  logic [7:0]                          i_blue_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [bap_pkg::COL_W-1:0]           o_block_column,
    output logic [bap_pkg::COL_W-1:0]           o_block_row,
    output logic [7:0]                          o_red_average,
    output logic [7:0]                          o_green_average,
    output logic [7:0]                          o_blue_average,
    output logic                                o_image_done
);

    bap_pkg::t_cfg                w_cfg;

    // position counters
    logic [bap_pkg::COL_W-1:0]    r_col, n_col;
    logic [bap_pkg::COL_W-1:0]    r_row, n_row;
    logic [bap_pkg::BS_W-1:0]     r_col_off, n_col_off;
    logic [bap_pkg::BS_W-1:0]     r_row_off, n_row_off;
    logic [bap_pkg::COL_W-1:0]    r_blk_col, n_blk_col;
    logic [bap_pkg::COL_W-1:0]    r_blk_row, n_blk_row;

    // clearing pass
    logic                         r_clr_busy;
    logic [bap_pkg::COL_W-1:0]    r_clr_addr;

    // stage 1: memory read returns
    logic                         r_s1_valid;
    logic                         r_s1_emit;
    bap_pkg::t_meta               r_s1_meta;
    logic [7:0]                   r_s1_red;
    logic [7:0]                   r_s1_green;
    logic [7:0]                   r_s1_blue;

    // stage 2: finished block sums
    logic                         r_s2_valid;
    bap_pkg::t_sums               r_s2_sums;
    bap_pkg::t_meta               r_s2_meta;

    // last write back, for same-column forwarding
    logic                         r_fw_valid;
    logic [bap_pkg::COL_W-1:0]    r_fw_addr;
    bap_pkg::t_sums               r_fw_data;

    logic                         w_accept;
    logic                         w_last_col;
    logic                         w_last_row;
    logic                         w_col_edge;
    logic                         w_row_edge;
    bap_pkg::t_sums               w_rdata;
    bap_pkg::t_sums               w_old;
    bap_pkg::t_sums               w_new;
    logic                         w_we;
    logic [bap_pkg::COL_W-1:0]    w_waddr;
    bap_pkg::t_sums               w_wdata;
    logic                         w_div_valid;
    bap_pkg::t_result             w_div_result;
    bap_pkg::t_result             w_head;
    logic [bap_pkg::FIFO_CW-1:0]  w_fifo_count;
    logic [bap_pkg::FIFO_CW-1:0]  w_occ;

    bap_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // results in the queue or still needing a queue slot
    assign w_occ = w_fifo_count
                 + bap_pkg::FIFO_CW'(r_s1_valid & r_s1_emit)
                 + bap_pkg::FIFO_CW'(r_s2_valid)
                 + bap_pkg::FIFO_CW'(w_div_valid);

    assign o_stall  = r_clr_busy | (w_occ >= bap_pkg::FIFO_CW'(bap_pkg::FIFO_DEPTH));
    assign w_accept = i_valid & ~o_stall;

    assign w_last_col = (r_col == w_cfg.w_m1);
    assign w_last_row = (r_row == w_cfg.h_m1);
    assign w_col_edge = w_last_col | (r_col_off == w_cfg.bs_m1);
    assign w_row_edge = w_last_row | (r_row_off == w_cfg.bs_m1);

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_col_off = r_col_off;
        n_row_off = r_row_off;
        n_blk_col = r_blk_col;
        n_blk_row = r_blk_row;
        if (w_last_col) begin
            n_col     = '0;
            n_col_off = '0;
            n_blk_col = '0;
            if (w_last_row) begin
                n_row     = '0;
                n_row_off = '0;
                n_blk_row = '0;
            end else begin
                n_row = r_row + 1'b1;
                if (r_row_off == w_cfg.bs_m1) begin
                    n_row_off = '0;
                    n_blk_row = r_blk_row + 1'b1;
                end else begin
                    n_row_off = r_row_off + 1'b1;
                end
            end
        end else begin
            n_col = r_col + 1'b1;
            if (r_col_off == w_cfg.bs_m1) begin
                n_col_off = '0;
                n_blk_col = r_blk_col + 1'b1;
            end else begin
                n_col_off = r_col_off + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_off  <= '0;
            r_row_off  <= '0;
            r_blk_col  <= '0;
            r_blk_row  <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid & r_s1_emit;
            r_fw_valid <= r_s1_valid & ~r_clr_busy & ~w_cfg.restart;
            if (w_cfg.restart) begin
                r_col      <= '0;
                r_row      <= '0;
                r_col_off  <= '0;
                r_row_off  <= '0;
                r_blk_col  <= '0;
                r_blk_row  <= '0;
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else begin
                if (r_clr_busy) begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == bap_pkg::COL_W'(bap_pkg::MAX_WIDTH - 1)) begin
                        r_clr_busy <= 1'b0;
                    end
                end
                if (w_accept) begin
                    r_col     <= n_col;
                    r_row     <= n_row;
                    r_col_off <= n_col_off;
                    r_row_off <= n_row_off;
                    r_blk_col <= n_blk_col;
                    r_blk_row <= n_blk_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_emit           <= w_col_edge & w_row_edge;
            r_s1_meta.block_col <= r_blk_col;
            r_s1_meta.block_row <= r_blk_row;
            r_s1_meta.done      <= w_last_col & w_last_row;
            r_s1_red            <= i_red_in;
            r_s1_green          <= i_green_in;
            r_s1_blue           <= i_blue_in;
        end
        if (r_s1_valid & r_s1_emit) begin
            r_s2_sums <= w_new;
            r_s2_meta <= r_s1_meta;
        end
        r_fw_addr <= w_waddr;
        r_fw_data <= w_wdata;
    end

    bap_sum_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_blk_col),
        .o_rdata (w_rdata)
    );

    // the previous write back to the same column is not yet in the read data
    assign w_old = (r_fw_valid && (r_fw_addr == r_s1_meta.block_col)) ? r_fw_data : w_rdata;

    assign w_new.r = w_old.r + bap_pkg::SUM_W'(r_s1_red);
    assign w_new.g = w_old.g + bap_pkg::SUM_W'(r_s1_green);
    assign w_new.b = w_old.b + bap_pkg::SUM_W'(r_s1_blue);

    // a finished block leaves its column cleared for the next band
    assign w_we    = r_clr_busy | r_s1_valid;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_s1_meta.block_col;
    assign w_wdata = (r_clr_busy | r_s1_emit) ? '0 : w_new;

    bap_recip_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .i_sums   (r_s2_sums),
        .i_meta   (r_s2_meta),
        .i_recip  (w_cfg.recip),
        .o_valid  (w_div_valid),
        .o_result (w_div_result)
    );

    bap_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_div_valid),
        .i_data  (w_div_result),
        .i_pop   (~i_stall),
        .o_valid (o_valid),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    assign o_block_column  = w_head.meta.block_col;
    assign o_block_row     = w_head.meta.block_row;
    assign o_red_average   = w_head.red;
    assign o_green_average = w_head.green;
    assign o_blue_average  = w_head.blue;
    assign o_image_done    = w_head.meta.done;

    `BAP_ASSERT_IMP(a_no_pixel_in_clear, i_clk, i_rst_n, r_clr_busy, o_stall, "pixel taken during clear")
    `BAP_ASSERT_IMP(a_queue_credit, i_clk, i_rst_n, 1'b1, w_occ <= bap_pkg::FIFO_CW'(bap_pkg::FIFO_DEPTH), "result queue overbooked")
    `BAP_ASSERT_NXT(a_restart_clears, i_clk, i_rst_n, w_cfg.restart, r_clr_busy && (r_clr_addr == '0), "register write did not restart clear")
    `BAP_ASSERT_NXT(a_emit_to_divide, i_clk, i_rst_n, r_s1_valid && r_s1_emit, r_s2_valid, "finished block lost before divide")

endmodule
